[design/fqir_pkg.sv]
`default_nettype none

package fqir_pkg;

   // Fixed field widths of the two channels.
   localparam int OPCODE_W = 3;
   localparam int JOB_W    = 16;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // Default sizing of the queue.
   localparam int DEFAULT_DEPTH        = 16;
   localparam int DEFAULT_HANDLE_WIDTH = 16;

   // Operation codes carried by a request item.
   typedef enum logic [OPCODE_W-1:0] {
      OP_ENQ    = 3'd0,
      OP_DEQ    = 3'd1,
      OP_READ   = 3'd2,
      OP_REMOVE = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   // Status codes returned with every response item.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   // Per-cell controls: load from the tail input or shift from the neighbor.
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

`default_nettype wire

[design/fqir_if.sv]
`default_nettype none

// Request channel: one operation per item.
interface fqir_req_if;
   logic                         valid;
   logic                         ready;
   logic [fqir_pkg::OPCODE_W-1:0] opcode;
   logic [fqir_pkg::JOB_W-1:0]    job_in;
   logic [fqir_pkg::POS_W-1:0]    position;

   modport source (output valid, output opcode, output job_in, output position,
                   input ready);
   modport sink   (input valid, input opcode, input job_in, input position,
                   output ready);
endinterface

// Response channel: one result item per request item.
interface fqir_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fqir_pkg::JOB_W-1:0]    job_out;
   logic [fqir_pkg::COUNT_W-1:0]  count_out;
   logic [fqir_pkg::STATUS_W-1:0] status;

   modport source (output valid, output job_out, output count_out, output status,
                   input ready);
   modport sink   (input valid, input job_out, input count_out, input status,
                   output ready);
endinterface

`default_nettype wire

[design/fqir_cell.sv]
`default_nettype none

// One queue slot. It loads a new handle at the tail or takes its upper
// neighbor's handle when an entry at or below it is removed.
module fqir_cell #(
   parameter int WIDTH = fqir_pkg::DEFAULT_HANDLE_WIDTH
) (
   input  wire logic                  clock,
   input  wire fqir_pkg::cell_ctl_type ctl,
   input  wire logic [WIDTH-1:0]      load_data,
   input  wire logic [WIDTH-1:0]      next_data,
   output logic      [WIDTH-1:0]      data
);
   import fqir_pkg::*;

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   // Select the new slot contents.
   always_comb begin
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   // Payload register, no reset needed.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

[design/fifo_queue_indexed_remove.sv]
// Channel   Direction  Fields                        Accepted when
// req       in         opcode, job_in, position      req.valid && req.ready
// rsp       out        job_out, count_out, status    rsp.valid && rsp.ready
//
// One item may be accepted each cycle while the output register is free
// or its item is being taken. The row of cells shifts in parallel, so
// remove at any position is no slower than dequeue; the read mux over
// the cells sets the longest path. Results go to an output register.
// Reset empties the queue and drops the output register. A stalled
// response holds its item and stalls the request side until it is taken.
`default_nettype none

module fifo_queue_indexed_remove #(
   parameter int DEPTH        = fqir_pkg::DEFAULT_DEPTH,
   parameter int HANDLE_WIDTH = fqir_pkg::DEFAULT_HANDLE_WIDTH
) (
   input wire logic  clock,
   input wire logic  reset,
   fqir_req_if.sink  req,
   fqir_rsp_if.source rsp
);
   import fqir_pkg::*;

   // Stored handle width never exceeds the port width.
   localparam int SW   = (HANDLE_WIDTH < JOB_W) ? HANDLE_WIDTH : JOB_W;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int IW   = $clog2(DEPTH);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                rsp_valid_ff;
   logic [JOB_W-1:0]    job_out_ff;
   logic [JOB_W-1:0]    job_out_in;
   logic [COUNT_W-1:0]  count_out_ff;
   logic [STATUS_W-1:0] status_ff;
   status_type          status_in;

   logic                accept;
   logic                is_empty;
   logic                is_full;
   logic                pos_ok;
   logic [CMPW-1:0]     pos_ext;
   logic [CMPW-1:0]     count_ext;
   logic [IW-1:0]       pos_idx;
   logic [IW-1:0]       sel_idx;
   logic                enq_ok;
   logic                take_ok;
   logic                out_ok;
   logic [SW-1:0]       new_job;

   cell_ctl_type        ctl [DEPTH];
   logic [SW-1:0]       cell_data [DEPTH];

   assign accept    = req.valid && req.ready;
   assign req.ready = !rsp_valid_ff || rsp.ready;

   // Bounds and emptiness of the current queue.
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CW'(DEPTH));
   assign pos_ext   = CMPW'(req.position);
   assign count_ext = CMPW'(count_ff);
   assign pos_ok    = pos_ext < count_ext;
   assign pos_idx   = pos_ext[IW-1:0];
   assign new_job   = req.job_in[SW-1:0];

   // Decode the operation into status, cell controls and the next count.
   always_comb begin
      enq_ok    = 1'b0;
      take_ok   = 1'b0;
      out_ok    = 1'b0;
      sel_idx   = pos_idx;
      status_in = ST_OK;
      count_in  = count_ff;
      unique case (req.opcode)
         OP_ENQ: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               enq_ok   = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         OP_DEQ: begin
            sel_idx = '0;
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               take_ok  = 1'b1;
               out_ok   = 1'b1;
               count_in = count_ff - CW'(1);
            end
         end
         OP_READ: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else if (!pos_ok) begin
               status_in = ST_BADPOS;
            end else begin
               out_ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else if (!pos_ok) begin
               status_in = ST_BADPOS;
            end else begin
               take_ok  = 1'b1;
               out_ok   = 1'b1;
               count_in = count_ff - CW'(1);
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Handle produced by dequeue, read or remove; zero otherwise.
   assign job_out_in = out_ok ? JOB_W'(cell_data[sel_idx]) : '0;

   // Row of cells; each one but the last shifts down from its upper neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign ctl[i].load  = accept && enq_ok && (count_ff == CW'(i));
      assign ctl[i].shift = accept && take_ok && (sel_idx <= IW'(i));

      if (i == DEPTH - 1) begin : g_last
         fqir_cell #(.WIDTH(SW)) u_cell (
            .clock     (clock),
            .ctl       (ctl[i]),
            .load_data (new_job),
            .next_data (cell_data[i]),
            .data      (cell_data[i])
         );
      end else begin : g_mid
         fqir_cell #(.WIDTH(SW)) u_cell (
            .clock     (clock),
            .ctl       (ctl[i]),
            .load_data (new_job),
            .next_data (cell_data[i+1]),
            .data      (cell_data[i])
         );
      end
   end

   // Count and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         job_out_ff   <= job_out_in;
         count_out_ff <= COUNT_W'(count_in);
         status_ff    <= status_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.job_out   = job_out_ff;
   assign rsp.count_out = count_out_ff;
   assign rsp.status    = status_ff;

endmodule

`default_nettype wire

[design/fqir_checker.sv]
`default_nettype none

// Port-level checks on the response stream of the queue.
module fqir_checker #(
   parameter int DEPTH = fqir_pkg::DEFAULT_DEPTH
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [fqir_pkg::JOB_W-1:0]    rsp_job_out,
   input wire logic [fqir_pkg::COUNT_W-1:0]  rsp_count_out,
   input wire logic [fqir_pkg::STATUS_W-1:0] rsp_status
);
   import fqir_pkg::*;

   // A refused operation never produces a handle.
   a_err_no_job: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_job_out == '0))
      else $error("refused operation returned a handle");

   // Full is reported only with the queue at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> (rsp_count_out == COUNT_W'(DEPTH)))
      else $error("full status with count below capacity");

   // Empty is reported only with no entries.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_count_out == '0))
      else $error("empty status with nonzero count");

   // No response right after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_job_out)
         && $stable(rsp_count_out) && $stable(rsp_status))
      else $error("stalled response item changed");

endmodule

bind fifo_queue_indexed_remove fqir_checker #(.DEPTH(DEPTH)) u_fqir_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_job_out   (rsp.job_out),
   .rsp_count_out (rsp.count_out),
   .rsp_status    (rsp.status)
);

`default_nettype wire
